// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the quantizer core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define CQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define CQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cqd_pkg.sv -----
// ---------------------------------------------------------------------------
// cqd_pkg
// Widths, codes and shared types of the coefficient quantizer core.
// ---------------------------------------------------------------------------
package cqd_pkg;

    localparam int COEF_W     = 16;
    localparam int WEIGHT_W   = 20;
    localparam int MAG_W      = COEF_W + 1;
    localparam int RES_W      = 16;
    localparam int CNT_W      = 11;
    localparam int MODE_W     = 2;
    localparam int SCALE_W    = 16;
    localparam int SHIFT_W    = 5;
    localparam int ROUND_W    = 31;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam int MAX_COEFFS_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CNT_LIMIT       = 2047;

    localparam int WQ_ROUND_BIT = 18;
    localparam int WQ_SHIFT     = 19;

    localparam logic [MODE_W-1:0] MODE_QUANT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WQUANT  = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING = 2'd3;

    localparam logic [MODE_W-1:0]  MODE_RST     = MODE_QUANT;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd32768;
    localparam logic [SHIFT_W-1:0] SHIFT_RST    = 5'd15;
    localparam logic [ROUND_W-1:0] ROUNDING_RST = '0;

    typedef enum logic [1:0] {
        OP_QUANT,
        OP_WQUANT,
        OP_DEQUANT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SHIFT_W-1:0] shift;
        logic [ROUND_W-1:0] rounding;
    } arith_cfg_t;

endpackage

// ----- rtl/core/cqd_front.sv -----
// ---------------------------------------------------------------------------
// cqd_front
// Input register: takes items, splits sign and magnitude, decodes the mode.
// ---------------------------------------------------------------------------
module cqd_front import cqd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // coefficient, weight, zero pad
    input  logic                  s_tlast,
    input  logic [MODE_W-1:0]     mode,
    input  q_status_t             q_status,
    output logic                  push,
    output item_t                 push_item
);

    logic                hold_valid_reg, hold_valid_next;
    item_t               hold_item_reg;
    item_t               item_in;
    logic [COEF_W-1:0]   coef;
    logic [MAG_W-1:0]    coef_ext;
    logic                take;

    assign coef     = s_tdata[COEF_W-1:0];
    assign coef_ext = {coef[COEF_W-1], coef};

    always_comb begin
        item_in.neg    = coef[COEF_W-1];
        item_in.mag    = coef[COEF_W-1] ? (~coef_ext + MAG_W'(1)) : coef_ext;
        item_in.weight = s_tdata[COEF_W +: WEIGHT_W];
        item_in.last   = s_tlast;
        unique case (mode)
            MODE_QUANT:  item_in.op = OP_QUANT;
            MODE_WQUANT: item_in.op = OP_WQUANT;
            default:     item_in.op = OP_DEQUANT;
        endcase
    end

    assign s_tready  = !hold_valid_reg || !q_status.full;
    assign take      = s_tvalid && s_tready;
    assign push      = hold_valid_reg && !q_status.full;
    assign push_item = hold_item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (take) begin
            hold_valid_next = 1'b1;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        if (take) begin
            hold_item_reg <= item_in;
        end
    end

endmodule

// ----- rtl/core/cqd_queue.sv -----
// ---------------------------------------------------------------------------
// cqd_queue
// Short first-in first-out queue between the front and the arithmetic.
// ---------------------------------------------------------------------------
module cqd_queue import cqd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     pop_item,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    item_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    assign q_status.full  = (fill_reg == FILL_FULL);
    assign q_status.empty = (fill_reg == '0);
    assign pop_item       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/cqd_back.sv -----
// ---------------------------------------------------------------------------
// cqd_back
// Arithmetic pipeline: weight, scale, round, shift, saturate, count nonzeros.
// ---------------------------------------------------------------------------
module cqd_back import cqd_pkg::*; #(
    parameter int MAX_COEFFS = MAX_COEFFS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  arith_cfg_t            cfg,
    input  q_status_t             q_status,
    input  item_t                 pop_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // result, nonzero_count, zero pad
    output logic                  m_tlast
);

    localparam int CAP = (MAX_COEFFS < CNT_LIMIT) ? MAX_COEFFS : CNT_LIMIT;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
    localparam int P1_W  = MAG_W + WEIGHT_W;
    localparam int P3_W  = MAG_W + SCALE_W;
    localparam int ACC_W = P3_W + 2;
    localparam logic [P1_W-1:0] WQ_ADD = P1_W'(1) << WQ_ROUND_BIT;
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] R_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] R_MIN = -ACC_W'(32768);

    typedef struct packed {
        op_t  op;
        logic neg;
        logic last;
    } tag_t;

    logic                      advance;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    tag_t                      t1_reg, t2_reg, t3_reg, t4_reg;
    logic [P1_W-1:0]           p1_reg, p1_next;
    logic [P3_W-1:0]           x2_reg, x2_next;
    logic [P3_W-1:0]           p3_reg, p3_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [RES_W-1:0]          res_reg, res_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      last_reg;
    logic [CNT_W-1:0]          run_reg, run_next;
    logic [WEIGHT_W-1:0]       mulb;
    logic signed [ACC_W-1:0]   mag_s, add_s, sh, qm, rv;

    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && !q_status.empty;

    // weight or scale product
    always_comb begin
        mulb    = (pop_item.op == OP_WQUANT) ? pop_item.weight : WEIGHT_W'(cfg.scale);
        p1_next = P1_W'(pop_item.mag) * P1_W'(mulb);
    end

    // weighted magnitude, rounded
    always_comb begin
        if (t1_reg.op == OP_WQUANT) begin
            x2_next = P3_W'((p1_reg + WQ_ADD) >> WQ_SHIFT);
        end else begin
            x2_next = p1_reg[P3_W-1:0];
        end
    end

    // second scale for the weighted path
    always_comb begin
        if (t2_reg.op == OP_WQUANT) begin
            p3_next = P3_W'(x2_reg[MAG_W-1:0]) * P3_W'(cfg.scale);
        end else begin
            p3_next = x2_reg;
        end
    end

    // rounding offset
    always_comb begin
        mag_s = $signed({2'b00, p3_reg});
        if (t3_reg.op == OP_DEQUANT) begin
            add_s    = (cfg.shift == '0) ? '0 : (ACC_W'(1) << (cfg.shift - SHIFT_W'(1)));
            acc_next = (t3_reg.neg ? -mag_s : mag_s) + add_s;
        end else begin
            add_s    = $signed(ACC_W'(cfg.rounding));
            acc_next = mag_s + add_s;
        end
    end

    // shift, saturate, count
    always_comb begin
        sh = acc_reg >>> cfg.shift;
        qm = (sh > Q_MAX) ? Q_MAX : sh;
        if (t4_reg.op == OP_DEQUANT) begin
            rv = sh;
        end else begin
            rv = t4_reg.neg ? -qm : qm;
        end
        priority if (rv > R_MAX) begin
            res_next = RES_W'(R_MAX);
        end else if (rv < R_MIN) begin
            res_next = RES_W'(R_MIN);
        end else begin
            res_next = rv[RES_W-1:0];
        end
        cnt_next = ((res_next != '0) && (run_reg < CAP_C)) ? run_reg + CNT_W'(1) : run_reg;
        run_next = t4_reg.last ? '0 : cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= '0;
        end else if (advance) begin
            v1_reg        <= !q_status.empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v4_reg) begin
                run_reg <= run_next;
            end
        end
        if (advance) begin
            t1_reg   <= '{op: pop_item.op, neg: pop_item.neg, last: pop_item.last};
            p1_reg   <= p1_next;
            t2_reg   <= t1_reg;
            x2_reg   <= x2_next;
            t3_reg   <= t2_reg;
            p3_reg   <= p3_next;
            t4_reg   <= t3_reg;
            acc_reg  <= acc_next;
            res_reg  <= res_next;
            cnt_reg  <= cnt_next;
            last_reg <= t4_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W - CNT_W)'(0), cnt_reg, res_reg};

endmodule

// ----- rtl/core/coefficient_quantizer_dequantizer.sv -----
// ---------------------------------------------------------------------------
// coefficient_quantizer_dequantizer
// Streaming quantizer and dequantizer for transform coefficients.
// ---------------------------------------------------------------------------
// Takes one coefficient per clock and gives one result per clock while the
// output side keeps m_tready high. An item passes an input register, a queue
// of QUEUE_DEPTH entries and a five-stage arithmetic pipeline (weight product,
// weight rounding, scale product, rounding add, shift and saturate). The
// pipeline advances as a whole: a stalled output holds it, the queue then
// fills and s_tready falls. Change the registers only while no item is in flight.
`include "assert_macros.svh"

module coefficient_quantizer_dequantizer import cqd_pkg::*; #(
    parameter int MAX_COEFFS  = MAX_COEFFS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // coefficient[15:0], weight[35:16]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // result[15:0], nonzero_count[26:16]
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CAP = (MAX_COEFFS < CNT_LIMIT) ? MAX_COEFFS : CNT_LIMIT;

    logic [MODE_W-1:0]  mode_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [ROUND_W-1:0] rounding_reg;
    arith_cfg_t         arith_cfg;
    q_status_t          q_status;
    logic               push, pop;
    item_t              push_item, pop_item;
    logic [RES_W-1:0]   out_level;
    logic [CNT_W-1:0]   out_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RST;
            scale_reg    <= SCALE_RST;
            shift_reg    <= SHIFT_RST;
            rounding_reg <= ROUNDING_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                CFG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                CFG_SHIFT:    shift_reg    <= cfg_data[SHIFT_W-1:0];
                CFG_ROUNDING: rounding_reg <= cfg_data[ROUND_W-1:0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    assign arith_cfg = '{scale: scale_reg, shift: shift_reg, rounding: rounding_reg};

    cqd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .mode      (mode_reg),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    cqd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    cqd_back #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (arith_cfg),
        .q_status  (q_status),
        .pop_item  (pop_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign out_level = m_tdata[RES_W-1:0];
    assign out_count = m_tdata[RES_W +: CNT_W];

    `CQD_ASSERT_NOW(a_count_cap, m_tvalid, out_count <= CNT_W'(CAP), "count above cap")
    `CQD_ASSERT_NOW(a_nonzero_counted, m_tvalid && (out_level != '0), out_count != '0,
                    "nonzero result not counted")
    `CQD_ASSERT_NEXT(a_count_restart, m_tvalid && m_tready && m_tlast,
                     !m_tvalid || (out_count <= CNT_W'(1)), "count not restarted after last")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for coefficient_quantizer_dequantizer.
// A directed table covers reset values, field extremes, every mode, shift
// zero, large rounding on zero coefficients and the spare mode code. Random
// phases under changing register settings, a long output stall and one long
// block of nonzero levels follow. Every result is checked against a local
// predictor of the quantizer and its running count, or a row's own values.
// ----------------------------------------------------------------------------
module testbench;
    import cqd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_DEQUANT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    localparam int COUNT_CAP       = (MAX_COEFFS_DEF < CNT_LIMIT) ? MAX_COEFFS_DEF : CNT_LIMIT;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 40;
    localparam int QUIET_PHASE     = 4;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_CYCLES     = 80;
    localparam int LONG_BLOCK_ITEMS = 60;
    localparam int STUCK_LIMIT     = 2000;
    localparam int END_PAUSE       = 20;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   value;
        logic signed [COEF_W-1:0] coef;
        logic [WEIGHT_W-1:0]     weight;
        logic                    last;
        logic                    known;
        logic signed [RES_W-1:0] level;
        logic [CNT_W-1:0]        count;
    } dir_row_t;

    typedef struct packed {
        logic signed [RES_W-1:0] level;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } quant_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [MODE_W-1:0]  cur_mode     = MODE_RST;
    logic [SCALE_W-1:0] cur_scale    = SCALE_RST;
    logic [SHIFT_W-1:0] cur_shift    = SHIFT_RST;
    logic [ROUND_W-1:0] cur_rounding = ROUNDING_RST;
    logic [CNT_W-1:0]   nz_running   = '0;

    quant_result_t expected_levels[$];
    dir_row_t      directed_rows[$];

    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;
    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int stuck_cycles    = 0;

    coefficient_quantizer_dequantizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic quant_result_t quantize_coefficient(
            input logic signed [COEF_W-1:0] coef, input logic [WEIGHT_W-1:0] weight,
            input logic last);
        quant_result_t     r;
        longint            cv;
        longint            level;
        longint unsigned   mag;
        longint unsigned   lvl;
        cv = coef;
        if (cur_mode == MODE_QUANT || cur_mode == MODE_WQUANT) begin
            mag = (cv < 0) ? -cv : cv;
            if (cur_mode == MODE_WQUANT)
                mag = (mag * weight + (64'd1 << WQ_ROUND_BIT)) >> WQ_SHIFT;
            lvl = (mag * cur_scale + cur_rounding) >> cur_shift;
            if (lvl > 64'd32768)
                lvl = 64'd32768;
            level = (cv < 0) ? -longint'(lvl) : longint'(lvl);
        end else if (cv == 0) begin
            level = 0;
        end else begin
            level = cv * longint'(cur_scale)
                    + ((cur_shift == 0) ? 64'sd0 : (64'sd1 <<< (cur_shift - 1)));
            level = level >>> cur_shift;
        end
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        if (level != 0 && nz_running < COUNT_CAP)
            nz_running++;
        r.level = level[RES_W-1:0];
        r.count = nz_running;
        r.last  = last;
        if (last)
            nz_running = '0;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] value);
        dir_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic dir_row_t coef_row(input logic signed [COEF_W-1:0] coef,
            input logic [WEIGHT_W-1:0] weight, input logic last, input logic known = 1'b0,
            input logic signed [RES_W-1:0] level = '0, input logic [CNT_W-1:0] count = '0);
        dir_row_t r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.coef   = coef;
        r.weight = weight;
        r.last   = last;
        r.known  = known;
        r.level  = level;
        r.count  = count;
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coefficient();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 128) - 64;
            2: return $urandom_range(0, 8190) - 4095;
            default: begin
                case ($urandom_range(0, 4))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 19);
    endfunction

    task automatic send_coefficient(input logic signed [COEF_W-1:0] coef,
            input logic [WEIGHT_W-1:0] weight, input logic last, input logic known = 1'b0,
            input logic signed [RES_W-1:0] level = '0, input logic [CNT_W-1:0] count = '0);
        quant_result_t want;
        int gap;
        gap = 0;
        if (!tx_steady)
            while (gap < 12 && $urandom_range(0, 99) < 25)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - COEF_W - WEIGHT_W){1'b0}}, weight, coef};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        want = quantize_coefficient(coef, weight, last);
        if (known) begin
            want.level = level;
            want.count = count;
        end
        expected_levels.push_back(want);
        items_sent++;
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_levels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
            input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:     cur_mode     = value[MODE_W-1:0];
            CFG_SCALE:    cur_scale    = value[SCALE_W-1:0];
            CFG_SHIFT:    cur_shift    = value[SHIFT_W-1:0];
            CFG_ROUNDING: cur_rounding = value[ROUND_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input logic [SCALE_W-1:0] scale,
            input logic [SHIFT_W-1:0] shift, input logic [ROUND_W-1:0] rounding);
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_SCALE, CFG_DATA_W'(scale));
        write_reg(CFG_SHIFT, CFG_DATA_W'(shift));
        write_reg(CFG_ROUNDING, CFG_DATA_W'(rounding));
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= rx_steady || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge aclk) begin
        quant_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_levels.size() == 0) begin
                $error("unexpected result: level %0d", $signed(m_tdata[RES_W-1:0]));
                mismatches++;
            end else begin
                want = expected_levels.pop_front();
                results_checked++;
                if (m_tdata[RES_W-1:0] !== want.level) begin
                    $error("result: expected %0d, got %0d", want.level,
                           $signed(m_tdata[RES_W-1:0]));
                    mismatches++;
                end
                if (m_tdata[RES_W +: CNT_W] !== want.count) begin
                    $error("nonzero_count: expected %0d, got %0d", want.count,
                           m_tdata[RES_W +: CNT_W]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_out: expected %0b, got %0b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no handshake for %0d cycles", STUCK_LIMIT);
            $display("FAIL coefficient_quantizer_dequantizer");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic [MODE_W-1:0]  ph_mode;
        logic [SCALE_W-1:0] ph_scale;
        logic [SHIFT_W-1:0] ph_shift;
        logic [ROUND_W-1:0] ph_round;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register values after reset give level equal to the coefficient
        directed_rows.push_back(coef_row(0, 0, 1'b0, 1'b1, 0, 0));
        directed_rows.push_back(coef_row(32767, 20'hFFFFF, 1'b0, 1'b1, 32767, 1));
        directed_rows.push_back(coef_row(-32768, 0, 1'b0, 1'b1, -32768, 2));
        directed_rows.push_back(coef_row(-1, 0, 1'b1, 1'b1, -1, 3));
        directed_rows.push_back(reg_row(CFG_SCALE, 32'hFFFF));
        directed_rows.push_back(reg_row(CFG_SHIFT, 0));
        directed_rows.push_back(coef_row(32767, 0, 1'b0, 1'b1, 32767, 1));
        directed_rows.push_back(coef_row(-32768, 0, 1'b1, 1'b1, -32768, 2));
        // large rounding turns a zero coefficient into a positive level
        directed_rows.push_back(reg_row(CFG_SCALE, 0));
        directed_rows.push_back(reg_row(CFG_SHIFT, 30));
        directed_rows.push_back(reg_row(CFG_ROUNDING, 32'h7FFF_FFFF));
        directed_rows.push_back(coef_row(0, 0, 1'b0, 1'b1, 1, 1));
        directed_rows.push_back(coef_row(-5, 0, 1'b0, 1'b1, -1, 2));
        directed_rows.push_back(coef_row(32767, 0, 1'b1, 1'b1, 1, 3));
        directed_rows.push_back(reg_row(CFG_MODE, MODE_WQUANT));
        directed_rows.push_back(reg_row(CFG_SCALE, 32768));
        directed_rows.push_back(reg_row(CFG_SHIFT, 15));
        directed_rows.push_back(reg_row(CFG_ROUNDING, 0));
        directed_rows.push_back(coef_row(32767, 20'hFFFFF, 1'b0));
        directed_rows.push_back(coef_row(-32768, 0, 1'b0));
        directed_rows.push_back(coef_row(100, 20'h80000, 1'b0));
        directed_rows.push_back(coef_row(-32768, 20'hFFFFF, 1'b1));
        directed_rows.push_back(reg_row(CFG_MODE, MODE_DEQUANT));
        directed_rows.push_back(reg_row(CFG_SCALE, 32'hFFFF));
        directed_rows.push_back(reg_row(CFG_SHIFT, 1));
        directed_rows.push_back(coef_row(0, 20'hFFFFF, 1'b0, 1'b1, 0, 0));
        directed_rows.push_back(coef_row(1, 0, 1'b0));
        directed_rows.push_back(coef_row(-1, 0, 1'b0));
        directed_rows.push_back(coef_row(32767, 0, 1'b0));
        directed_rows.push_back(coef_row(-32768, 0, 1'b1));
        // dequantize with no shift and no rounding offset
        directed_rows.push_back(reg_row(CFG_SHIFT, 0));
        directed_rows.push_back(coef_row(-1, 0, 1'b0, 1'b1, -32768, 1));
        directed_rows.push_back(coef_row(2, 0, 1'b1));
        directed_rows.push_back(reg_row(CFG_SHIFT, 31));
        directed_rows.push_back(coef_row(32767, 0, 1'b0));
        directed_rows.push_back(coef_row(-32768, 0, 1'b1));
        // the spare mode code behaves as dequantize
        directed_rows.push_back(reg_row(CFG_SHIFT, 4));
        directed_rows.push_back(reg_row(CFG_MODE, MODE_SPARE));
        directed_rows.push_back(coef_row(-7, 0, 1'b0));
        directed_rows.push_back(coef_row(9, 0, 1'b1));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_coefficient(directed_rows[i].coef, directed_rows[i].weight,
                                 directed_rows[i].last, directed_rows[i].known,
                                 directed_rows[i].level, directed_rows[i].count);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                ph_mode  = MODE_QUANT;
                ph_scale = '0;
                ph_shift = '0;
                ph_round = '0;
            end else if (p == 1) begin
                ph_mode  = MODE_WQUANT;
                ph_scale = '1;
                ph_shift = '1;
                ph_round = '1;
            end else begin
                ph_mode  = MODE_W'((p + 2) % 4);
                ph_scale = $urandom;
                ph_shift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(10, 22);
                case ($urandom_range(0, 2))
                    0: ph_round = '0;
                    1: ph_round = (ph_shift == 0) ? '0 : ROUND_W'(1) << (ph_shift - 1);
                    default: ph_round = $urandom;
                endcase
            end
            configure(ph_mode, ph_scale, ph_shift, ph_round);
            tx_steady = (p == QUIET_PHASE || p == PRESSURE_PHASE);
            rx_steady = (p == QUIET_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == PRESSURE_PHASE && i == 8)
                    hold_request = 1'b1;
                send_coefficient(random_coefficient(), random_weight(),
                                 $urandom_range(0, 15) == 0);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // one long block of nonzero levels
        configure(MODE_DEQUANT, 1, 0, 0);
        for (int i = 0; i < LONG_BLOCK_ITEMS; i++)
            send_coefficient($urandom_range(0, 1) ? $urandom_range(1, 30000)
                                                  : -$urandom_range(1, 30000),
                             random_weight(), i == LONG_BLOCK_ITEMS - 1);

        settle();
        repeat (END_PAUSE) @(posedge aclk);
        $display("Covered %0d items and %0d register writes in all four mode codes,",
                 items_sent, reg_writes);
        $display("an output stall, a long nonzero block; %0d results checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("PASS coefficient_quantizer_dequantizer");
        end else begin
            $display("FAIL coefficient_quantizer_dequantizer");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cqd_pkg.sv
rtl/core/cqd_front.sv
rtl/core/cqd_queue.sv
rtl/core/cqd_back.sv
rtl/core/coefficient_quantizer_dequantizer.sv
tb/testbench.sv
